// ----- hdl/rgsf_pkg.sv -----
// Shared types and constants for the serpentine gray raster formatter.
// No dependencies; imported by every module of the block.
package rgsf_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int COUNT_LIMIT = 4096;
  localparam int CFG_W       = 13;
  localparam int MAXW_BITS   = $clog2(MAX_WIDTH + 1);
  localparam int WEFF_W      = (CFG_W > MAXW_BITS) ? CFG_W : MAXW_BITS;
  localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W       = $clog2(COUNT_LIMIT);
  localparam int ADDR_W      = $clog2(2 * MAX_WIDTH);
  localparam logic [7:0] CUTOFF   = 8'd20;
  localparam logic [7:0] FULL_LVL = 8'd255;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_ROW_WIDTH  = 3'd0;
  localparam logic [2:0] REG_ROW_COUNT  = 3'd1;
  localparam logic [2:0] REG_SERPENTINE = 3'd2;
  localparam logic [2:0] REG_MAP_LOW    = 3'd3;
  localparam logic [2:0] REG_MAP_HIGH   = 3'd4;

  typedef struct packed {
    logic [CFG_W-1:0] row_width;
    logic [CFG_W-1:0] row_count;
    logic             serpentine;
    logic [7:0]       map_low;
    logic [7:0]       map_high;
  } cfg_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       drain;
  } in_item_t;

  typedef struct packed {
    logic [7:0] intensity;
    logic       row_reversed;
    logic       last_in_row;
    logic       last_of_image;
  } out_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       rev;
    logic       last_row;
    logic       last_img;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } q_stat_t;

endpackage

// ----- hdl/raster_gray_serpentine_formatter_core.sv -----
// Top level of the serpentine gray raster formatter: APB register file,
// front end, queue and remap back end. Uses rgsf_pkg and all rgsf_* modules.
//
// Usage:
//  - in_valid/in_ready carry one in_item_t per transfer: a luma pixel in raster
//    order, or a drain item (drain = 1) that only pushes out buffered values.
//  - Pixels are inverted, cut below 20 and collected into one bank of a
//    ping-pong row store; the previous row is read back from the other bank,
//    one value per input transfer, right to left on odd rows in serpentine mode.
//  - out_valid/out_ready carry one out_item_t with intensity remapped into
//    map_low..map_high and row/image end flags.
//  - Throughput: one item per cycle while out_ready holds; the limit is the single read
//    port and single write port of the row store, one access of each per item.
//  - A receiver stall fills the pipeline registers and then the 4-entry queue;
//    in_ready drops once queue plus in-flight read reach that depth.
//  - Reset (rst_n low, synchronous) clears counters, banks and all valid flags;
//    the row store is not cleared, no clearing pass is needed, and registers
//    return to width 64, count 64, serpentine on, map 0..255.
//  - Registers must be written only while the block is idle (unenforced); pready is always high.
module raster_gray_serpentine_formatter_core import rgsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [2:0] reg_idx;
  q_push_t    q_push;
  q_stat_t    q_stat;
  q_entry_t   q_head;
  logic       q_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // register write decode; unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROW_WIDTH:  cfg_nxt.row_width  = pwdata[CFG_W-1:0];
        REG_ROW_COUNT:  cfg_nxt.row_count  = pwdata[CFG_W-1:0];
        REG_SERPENTINE: cfg_nxt.serpentine = pwdata[0];
        REG_MAP_LOW:    cfg_nxt.map_low    = pwdata[7:0];
        REG_MAP_HIGH:   cfg_nxt.map_high   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_width  <= CFG_W'(64);
      cfg_r.row_count  <= CFG_W'(64);
      cfg_r.serpentine <= 1'b1;
      cfg_r.map_low    <= '0;
      cfg_r.map_high   <= FULL_LVL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_ROW_WIDTH:  prdata = 32'(cfg_r.row_width);
      REG_ROW_COUNT:  prdata = 32'(cfg_r.row_count);
      REG_SERPENTINE: prdata = 32'(cfg_r.serpentine);
      REG_MAP_LOW:    prdata = 32'(cfg_r.map_low);
      REG_MAP_HIGH:   prdata = 32'(cfg_r.map_high);
      default:        prdata = '0;
    endcase
  end

  rgsf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push)
  );

  rgsf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (q_pop),
    .head   (q_head),
    .q_stat (q_stat)
  );

  rgsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // front-end credit check: a push lands on a full queue only together with a pop
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid && q_stat.full |-> q_pop)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue underflow");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && q_stat.empty)
    else $error("output or queue busy after reset");

  // when input is held off, the queue plus in-flight read must be nonempty
  a_ready_credit: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> !q_stat.empty || q_push.valid)
    else $error("input stalled with nothing in flight");
`endif

endmodule

// ----- hdl/rgsf_front.sv -----
// Front end: takes pixels, keeps row/column counters and the ping-pong row store,
// and issues one readout value per transfer into the queue. Uses rgsf_pkg.
module rgsf_front import rgsf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output q_push_t  q_push
);

  logic [COL_W-1:0] wcol_r, wcol_nxt, rcol_r, rcol_nxt;
  logic [ROW_W-1:0] wrow_r, wrow_nxt, rrow_r, rrow_nxt;
  logic             wbank_r, wbank_nxt, rready_r, rready_nxt;
  logic             pend_r;
  logic [7:0]       rd_data_r;
  q_entry_t         meta_r, meta_c;

  logic [7:0]       mem [2*MAX_WIDTH];

  logic [WEFF_W-1:0] w_eff, rcol_x, pos, col;
  logic [CFG_W-1:0]  h_eff;
  logic              accept, rd_en, wr_en, rlast, wlast;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [7:0]        wv;

  always_comb begin
    if (cfg.row_width == '0) begin
      w_eff = WEFF_W'(1);
    end else if (WEFF_W'(cfg.row_width) > WEFF_W'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(cfg.row_width);
    end
    if (cfg.row_count == '0) begin
      h_eff = CFG_W'(1);
    end else if (cfg.row_count > CFG_W'(COUNT_LIMIT)) begin
      h_eff = CFG_W'(COUNT_LIMIT);
    end else begin
      h_eff = cfg.row_count;
    end
  end

  // room for the in-flight read plus the queue contents
  assign in_ready = ((QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(pend_r)) < (QCNT_W+1)'(QDEPTH);
  assign accept   = in_valid && in_ready;
  assign rd_en    = accept && rready_r;
  assign wr_en    = accept && !in_data.drain;

  // readout side: bank opposite the one being filled
  always_comb begin
    rcol_x        = WEFF_W'(rcol_r);
    pos           = (rcol_x < w_eff) ? rcol_x : w_eff - WEFF_W'(1);
    meta_c        = '0;
    meta_c.rev    = cfg.serpentine && rrow_r[0];
    col           = meta_c.rev ? (w_eff - WEFF_W'(1) - pos) : pos;
    rlast         = (rcol_x + WEFF_W'(1)) >= w_eff;
    meta_c.last_row = rlast;
    meta_c.last_img = rlast && ((CFG_W'(rrow_r) + CFG_W'(1)) >= h_eff);
    rd_addr = wbank_r ? ADDR_W'(col[COL_W-1:0])
                      : ADDR_W'(col[COL_W-1:0]) + ADDR_W'(MAX_WIDTH);
  end

  // fill side
  always_comb begin
    wv      = ~in_data.luma;
    if (wv < CUTOFF) begin
      wv = '0;
    end
    wr_addr = wbank_r ? ADDR_W'(wcol_r) + ADDR_W'(MAX_WIDTH) : ADDR_W'(wcol_r);
    wlast   = (WEFF_W'(wcol_r) + WEFF_W'(1)) >= w_eff;
  end

  always_comb begin
    wcol_nxt   = wcol_r;
    wrow_nxt   = wrow_r;
    rcol_nxt   = rcol_r;
    rrow_nxt   = rrow_r;
    wbank_nxt  = wbank_r;
    rready_nxt = rready_r;
    if (rd_en) begin
      if (rlast) begin
        rready_nxt = 1'b0;
        rcol_nxt   = '0;
      end else begin
        rcol_nxt = rcol_r + COL_W'(1);
      end
    end
    if (wr_en) begin
      if (wlast) begin
        // row done: swap banks, new row takes over the readout
        wcol_nxt   = '0;
        wbank_nxt  = ~wbank_r;
        rready_nxt = 1'b1;
        rcol_nxt   = '0;
        rrow_nxt   = wrow_r;
        wrow_nxt   = ((CFG_W'(wrow_r) + CFG_W'(1)) >= h_eff) ? '0 : wrow_r + ROW_W'(1);
      end else begin
        wcol_nxt = wcol_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcol_r   <= '0;
      wrow_r   <= '0;
      rcol_r   <= '0;
      rrow_r   <= '0;
      wbank_r  <= 1'b0;
      rready_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      wcol_r   <= wcol_nxt;
      wrow_r   <= wrow_nxt;
      rcol_r   <= rcol_nxt;
      rrow_r   <= rrow_nxt;
      wbank_r  <= wbank_nxt;
      rready_r <= rready_nxt;
      pend_r   <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wv;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      meta_r    <= meta_c;
    end
  end

  always_comb begin
    q_push.valid       = pend_r;
    q_push.entry       = meta_r;
    q_push.entry.value = rd_data_r;
  end

endmodule

// ----- hdl/rgsf_queue.sv -----
// Short FIFO between the front end and the remap back end.
// Uses rgsf_pkg for the entry and status types.
module rgsf_queue import rgsf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  q_push_t  q_push,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  q_stat
);

  q_entry_t          store [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (q_push.valid) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
    end
    if (q_push.valid && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!q_push.valid && pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      store[wptr_r] <= q_push.entry;
    end
  end

  assign head         = store[rptr_r];
  assign q_stat.count = count_r;
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));

endmodule

// ----- hdl/rgsf_back.sv -----
// Back end: intensity remap (multiply stage, divide-by-255 and clamp stage)
// and the output register. Uses rgsf_pkg.
module rgsf_back import rgsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  q_entry_t  head,
  input  q_stat_t   q_stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic               p_valid_r, p_valid_nxt, o_valid_r, o_valid_nxt;
  logic signed [17:0] p_x_r, x_c;
  logic               p_byp_r, byp_c;
  q_entry_t           p_ent_r;
  logic [7:0]         p_lo_r;
  out_item_t          o_data_r, o_data_c;
  logic               o_ready, p_adv;

  logic signed [8:0]  diff;
  logic signed [17:0] neg;
  logic [16:0]        mag;
  logic [17:0]        sum;
  logic [7:0]         quo;
  logic signed [10:0] qs, r;

  assign o_ready = !o_valid_r || out_ready;
  assign p_adv   = !p_valid_r || o_ready;
  assign pop     = !q_stat.empty && p_adv;

  // stage 1: v*(hi-lo)+127
  always_comb begin
    diff  = $signed({1'b0, cfg.map_high}) - $signed({1'b0, cfg.map_low});
    x_c   = $signed({1'b0, head.value}) * diff + 18'sd127;
    byp_c = ((cfg.map_low == '0) && (cfg.map_high == FULL_LVL)) || (head.value == '0);
  end

  // stage 2: truncating divide by 255 via n/255 = (n + 1 + (n>>8)) >> 8
  always_comb begin
    neg = -p_x_r;
    mag = p_x_r[17] ? neg[16:0] : p_x_r[16:0];
    sum = {1'b0, mag} + 18'd1 + 18'(mag >> 8);
    quo = sum[15:8];
    qs  = p_x_r[17] ? -$signed({3'b000, quo}) : $signed({3'b000, quo});
    r   = $signed({3'b000, p_lo_r}) + qs;
    o_data_c.row_reversed  = p_ent_r.rev;
    o_data_c.last_in_row   = p_ent_r.last_row;
    o_data_c.last_of_image = p_ent_r.last_img;
    if (p_byp_r) begin
      o_data_c.intensity = p_ent_r.value;
    end else if (r < 11'sd0) begin
      o_data_c.intensity = '0;
    end else if (r > 11'sd255) begin
      o_data_c.intensity = FULL_LVL;
    end else begin
      o_data_c.intensity = r[7:0];
    end
  end

  always_comb begin
    p_valid_nxt = p_adv ? pop : p_valid_r;
    o_valid_nxt = o_ready ? p_valid_r : o_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_x_r   <= x_c;
      p_byp_r <= byp_c;
      p_ent_r <= head;
      p_lo_r  <= cfg.map_low;
    end
    if (o_ready && p_valid_r) begin
      o_data_r <= o_data_c;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

endmodule

// ----- test/tb_raster_gray_serpentine_formatter_core.sv -----
// Self-checking testbench for raster_gray_serpentine_formatter_core.
// Drives pixels and drains, predicts every scan result and checks it in order.
// Depends on rgsf_pkg and the formatter RTL.
module tb_raster_gray_serpentine_formatter_core;
  import rgsf_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no transfer before giving up
  localparam int TAIL_CYCLES = 8;     // settle time after the last result

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  raster_gray_serpentine_formatter_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scan predictor: register copy plus the ping-pong row state.
  // ---------------------------------------------------------------------------
  logic [12:0] cfg_width = 13'd64;
  logic [12:0] cfg_count = 13'd64;
  logic        cfg_serp  = 1'b1;
  logic [7:0]  cfg_lo    = 8'd0;
  logic [7:0]  cfg_hi    = 8'd255;

  logic [7:0]  row_banks [2*MAX_WIDTH];
  int unsigned wr_col = 0, wr_row = 0, rd_col = 0, rd_row = 0;
  bit          wr_bank = 1'b0;
  bit          row_pending = 1'b0;   // a finished row waits to be scanned out

  out_item_t   expected_scan[$];
  in_item_t    pixel_backlog[$];
  int          items_in_flight = 0;  // queued but not yet transferred
  int          mismatches = 0;
  int          random_items = 0;
  bit          quiet_flow = 1'b0;    // no gaps or stalls while set

  function automatic int unsigned eff_width(logic [12:0] w);
    if (w == '0) return 1;
    if (32'(w) > MAX_WIDTH) return MAX_WIDTH;
    return 32'(w);
  endfunction

  function automatic int unsigned eff_count(logic [12:0] c);
    if (c == '0) return 1;
    if (32'(c) > COUNT_LIMIT) return COUNT_LIMIT;
    return 32'(c);
  endfunction

  // Linear remap into cfg_lo..cfg_hi; signed division truncates toward zero.
  function automatic logic [7:0] scale_level(int unsigned v);
    int lo, hi, r;
    lo = int'(cfg_lo);
    hi = int'(cfg_hi);
    if ((lo == 0 && hi == 255) || v == 0) return v[7:0];
    r = lo + (int'(v) * (hi - lo) + 127) / 255;
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r[7:0];
  endfunction

  // One accepted item: read one value of the waiting row (if any), then store
  // the pixel into the write bank and swap banks when the row fills.
  task automatic take_item(input in_item_t it);
    int unsigned w, h, pos, col, v;
    bit          rev, row_end;
    out_item_t   res;
    w = eff_width(cfg_width);
    h = eff_count(cfg_count);
    if (row_pending) begin
      rev = cfg_serp && ((rd_row & 1) != 0);
      pos = (rd_col < w) ? rd_col : w - 1;   // clamp after a width shrink
      col = rev ? (w - 1 - pos) : pos;
      v = 32'(row_banks[ADDR_W'((wr_bank ? 0 : MAX_WIDTH) + col)]);
      row_end = (rd_col + 1 >= w);
      res.intensity     = scale_level(v);
      res.row_reversed  = rev;
      res.last_in_row   = row_end;
      res.last_of_image = row_end && (rd_row + 1 >= h);
      expected_scan.push_back(res);
      if (row_end) begin
        row_pending = 1'b0;
        rd_col = 0;
      end else begin
        rd_col++;
      end
    end
    if (!it.drain) begin
      v = 255 - 32'(it.luma);
      if (v < 32'(CUTOFF)) v = 0;
      col = (wr_col < MAX_WIDTH) ? wr_col : MAX_WIDTH - 1;
      row_banks[ADDR_W'((wr_bank ? MAX_WIDTH : 0) + col)] = v[7:0];
      if (wr_col + 1 >= w) begin
        wr_col = 0;
        wr_bank ^= 1'b1;
        row_pending = 1'b1;
        rd_col = 0;
        rd_row = wr_row;
        wr_row = (wr_row + 1 >= h) ? 0 : wr_row + 1;
      end else begin
        wr_col++;
      end
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: presents backlog items, predicts at each transfer.
  // ---------------------------------------------------------------------------
  int unsigned send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        take_item(in_data);
        items_in_flight--;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pixel_backlog.size() > 0) begin
          in_data  <= pixel_backlog.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet_flow && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: in-order compare against the predicted scan.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scan_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_scan.size() == 0) begin
        $error("unexpected result: intensity %0d", out_data.intensity);
        mismatches++;
      end else begin
        want = expected_scan.pop_front();
        if (out_data.intensity !== want.intensity) begin
          $error("intensity: expected %0d, got %0d", want.intensity, out_data.intensity);
          mismatches++;
        end
        if (out_data.row_reversed !== want.row_reversed) begin
          $error("row_reversed: expected %0b, got %0b",
                 want.row_reversed, out_data.row_reversed);
          mismatches++;
        end
        if (out_data.last_in_row !== want.last_in_row) begin
          $error("last_in_row: expected %0b, got %0b",
                 want.last_in_row, out_data.last_in_row);
          mismatches++;
        end
        if (out_data.last_of_image !== want.last_of_image) begin
          $error("last_of_image: expected %0b, got %0b",
                 want.last_of_image, out_data.last_of_image);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic [7:0] luma, input bit drain);
    in_item_t it;
    it.luma  = luma;
    it.drain = drain;
    pixel_backlog.push_back(it);
    items_in_flight++;
  endtask

  // Wait until every item has gone in and every result has come out, then
  // let the pipeline settle for items that produced nothing.
  task automatic wait_idle();
    do @(posedge clk); while (items_in_flight != 0 || expected_scan.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; register lands when pready is seen high.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ROW_WIDTH:  cfg_width = val[12:0];
      REG_ROW_COUNT:  cfg_count = val[12:0];
      REG_SERPENTINE: cfg_serp  = val[0];
      REG_MAP_LOW:    cfg_lo    = val[7:0];
      REG_MAP_HIGH:   cfg_hi    = val[7:0];
      default: ;
    endcase
  endtask

  // Drain out whatever row is waiting.
  task automatic flush_row();
    int unsigned w, n;
    if (row_pending) begin
      w = eff_width(cfg_width);
      n = (rd_col < w) ? w - rd_col : 1;
      repeat (n) queue_item(8'($urandom_range(0, 255)), 1'b1);
      wait_idle();
    end
  endtask

  // Growing the width while a row waits would read bank entries never
  // written, so the waiting row is flushed first.
  task automatic set_width(input logic [12:0] w);
    if (row_pending && eff_width(w) > eff_width(cfg_width)) flush_row();
    write_reg(REG_ROW_WIDTH, {19'd0, w});
  endtask

  function automatic logic [7:0] pick_luma();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(230, 240));   // around the cutoff
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One random phase: optional register changes, then a burst of traffic.
  task automatic random_phase();
    int unsigned n, lo, hi;
    logic [12:0] w, c;
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0: w = 13'd0;
        1: w = 13'd1;
        2: w = 13'($urandom_range(13, 40));
        default: w = 13'($urandom_range(2, 12));
      endcase
      set_width(w);
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0: c = 13'd0;
        1: c = 13'($urandom_range(4095, 8191));
        default: c = 13'($urandom_range(1, 6));
      endcase
      write_reg(REG_ROW_COUNT, {19'd0, c});
    end
    if ($urandom_range(0, 1) == 0) write_reg(REG_SERPENTINE, $urandom_range(0, 1));
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0: begin lo = 0;   hi = 255; end
        1: begin lo = 255; hi = 0;   end
        2: begin lo = $urandom_range(0, 255); hi = lo; end
        default: begin lo = $urandom_range(0, 255); hi = $urandom_range(0, 255); end
      endcase
      write_reg(REG_MAP_LOW, lo);
      write_reg(REG_MAP_HIGH, hi);
    end
    quiet_flow = ($urandom_range(0, 4) == 0);
    n = $urandom_range(20, 80);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) queue_item(8'($urandom_range(0, 255)), 1'b1);
      else queue_item(pick_luma(), 1'b0);
    end
    random_items += n;
    // sender holds off here until every result is back
    wait_idle();
    if ($urandom_range(0, 2) == 0) flush_row();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed 1: 4 x 2 image, serpentine, identity map. Leading drain has
    // nothing buffered; first row covers full black/white and the cutoff edge.
    set_width(13'd4);
    write_reg(REG_ROW_COUNT, 32'd2);
    write_reg(REG_SERPENTINE, 32'd1);
    write_reg(REG_MAP_LOW, 32'd0);
    write_reg(REG_MAP_HIGH, 32'd255);
    queue_item(8'd77, 1'b1);
    queue_item(8'd0, 1'b0);
    queue_item(8'd255, 1'b0);
    queue_item(8'd236, 1'b0);
    queue_item(8'd235, 1'b0);
    queue_item(8'd128, 1'b0);
    queue_item(8'd1, 1'b0);
    queue_item(8'd254, 1'b0);
    queue_item(8'd100, 1'b0);
    repeat (4) queue_item(8'd255, 1'b1);   // odd row goes out reversed, image end
    queue_item(8'd0, 1'b1);
    wait_idle();

    // Directed 2: zero width and count act as one; inverted map.
    set_width(13'd0);
    write_reg(REG_ROW_COUNT, 32'd0);
    write_reg(REG_MAP_LOW, 32'd255);
    write_reg(REG_MAP_HIGH, 32'd0);
    queue_item(8'd0, 1'b0);
    queue_item(8'd100, 1'b0);
    queue_item(8'd236, 1'b0);
    queue_item(8'd9, 1'b1);
    queue_item(8'd9, 1'b1);
    wait_idle();

    // Directed 3: flat map, serpentine off.
    set_width(13'd3);
    write_reg(REG_ROW_COUNT, 32'd3);
    write_reg(REG_SERPENTINE, 32'd0);
    write_reg(REG_MAP_LOW, 32'd40);
    write_reg(REG_MAP_HIGH, 32'd40);
    queue_item(8'd10, 1'b0);
    queue_item(8'd0, 1'b0);
    queue_item(8'd250, 1'b0);
    repeat (3) queue_item(8'd0, 1'b1);
    wait_idle();

    // Width above the maximum: a partial row, then a shrink ends it mid-row.
    write_reg(REG_SERPENTINE, 32'd1);
    write_reg(REG_MAP_LOW, 32'd0);
    write_reg(REG_MAP_HIGH, 32'd255);
    write_reg(REG_ROW_COUNT, 32'd4096);
    set_width(13'd8191);
    repeat (40) queue_item(pick_luma(), 1'b0);
    wait_idle();
    set_width(13'd8);
    queue_item(pick_luma(), 1'b0);
    wait_idle();
    flush_row();

    // Count above the limit: single-pixel rows.
    set_width(13'd1);
    write_reg(REG_ROW_COUNT, 32'd8191);
    repeat (24) queue_item(pick_luma(), 1'b0);
    wait_idle();
    flush_row();

    while (random_items < 780) random_phase();

    quiet_flow = 1'b0;
    wait_idle();
    if (mismatches == 0 && expected_scan.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- raster_gray_serpentine_formatter_core.f -----
hdl/rgsf_pkg.sv
hdl/rgsf_front.sv
hdl/rgsf_queue.sv
hdl/rgsf_back.sv
hdl/raster_gray_serpentine_formatter_core.sv
test/tb_raster_gray_serpentine_formatter_core.sv
